FILE: rtl/assert_macros.svh
// Assertion macros used by the RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication or plain property on every rising clock edge outside reset.
`define SALC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define SALC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define SALC_ASSERT(lbl, clk, rst_n, prop)
`define SALC_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: rtl/salc_pkg.sv
// Types and constants of the set-associative LRU cache lookup block.
`timescale 1ns / 1ps

package salc_pkg;

	localparam int ADDR_W           = 64;
	localparam int TAG_W            = 64;
	localparam int CNT_W            = 32;
	localparam int OP_W             = 2;
	localparam int SET_BITS_W       = 4;
	localparam int BLOCK_BITS_W     = 6;
	localparam int WAYS_W           = 4;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 6;
	localparam int OUT_DATA_W       = 104;

	localparam int DEF_MAX_SET_BITS = 8;
	localparam int DEF_MAX_WAYS     = 8;

	localparam logic [SET_BITS_W-1:0]   RST_SET_BITS   = 4'd4;
	localparam logic [BLOCK_BITS_W-1:0] RST_BLOCK_BITS = 6'd4;
	localparam logic [WAYS_W-1:0]       RST_WAYS       = 4'd1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_STORE  = 2'd1,
		OP_MODIFY = 2'd2,
		OP_IFETCH = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS       = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/salc_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module salc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/set_assoc_lru_cache_lookup.sv
// Top level of the set-associative LRU cache lookup block.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// The s_axis channel carries one memory access per item: tuser is the access
// kind, tdata the 64-bit byte address. The m_axis channel returns one result
// per item with the hit, miss and eviction counts of that item and the
// saturating running totals. The cfg channel writes set_bits (index 0),
// block_bits (index 1) and ways (index 2); it is always ready and is meant
// to be written only while no item is in flight.
// Each set is one row of a RAM holding tag, valid bit and recency rank of
// every way. An item reads its row, walks the ways in use one per cycle
// through a single tag comparator, then writes the row back and registers
// its result; an instruction fetch skips the row read, walk and write-back.
// The next item is taken only once the previous one has left the done
// state, so items do not overlap.
// After reset the block clears the valid bits of all 2**MAX_SET_BITS sets
// (256 by default), one set per cycle, with s_axis_tready low.
// When the receiver stalls, the result stays in the output register and the
// next item is accepted, but it is held before write-back until the
// output register frees up.
module set_assoc_lru_cache_lookup
	import salc_pkg::*;
#(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ADDR_W-1:0]     s_axis_tdata,  // address
	input  logic [OP_W-1:0]       s_axis_tuser,  // op
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// hits[1:0], misses[2], evictions[3], total_hits[35:4], total_misses[67:36],
	// total_evictions[99:68], zero fill[103:100]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_SETS = 1 << MAX_SET_BITS;
	localparam int RW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W    = 1 + RW + TAG_W;
	localparam int ROW_W    = MAX_WAYS * WAY_W;
	localparam int WCW      = $clog2(MAX_WAYS + 1);
	localparam int SBW      = $clog2(MAX_SET_BITS + 1);
	localparam int TOT_W    = $clog2(MAX_SET_BITS + ADDR_W);
	localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);

	state_t state_q, state_d;

	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;
	logic [WAYS_W-1:0]       ways_q;

	logic [MAX_SET_BITS-1:0] clr_q;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [TAG_W-1:0]        tag_q;
	op_t                     op_q;
	logic [RW-1:0]           way_q;

	logic          hit_q, free_v_q, vic_v_q;
	logic [RW-1:0] hit_way_q, hit_rank_q, free_way_q, vic_way_q, vic_rank_q;

	logic       m_valid_q;
	logic [1:0] hits_q;
	logic       miss_q, evict_q;
	logic [CNT_W-1:0] tot_hits_q, tot_miss_q, tot_evict_q;

	logic [SBW-1:0]          sb_eff;
	logic [WCW-1:0]          w_eff;
	logic [TOT_W-1:0]        shift_total;
	logic [ADDR_W-1:0]       addr_shift;
	logic [TAG_W-1:0]        tag_in;
	logic [MAX_SET_BITS-1:0] set_in;

	logic             in_accept, out_load, scan_last, is_fetch, evict;
	logic [RW-1:0]    tgt_way;
	logic [ROW_W-1:0] row, row_new;
	logic [WAY_W-1:0] cur_way;
	logic             cur_valid;
	logic [RW-1:0]    cur_rank;
	logic [TAG_W-1:0] cur_tag;
	logic [1:0]       h_cnt;
	logic             m_cnt, e_cnt;
	logic [CNT_W:0]   sum_h, sum_m, sum_e;

	logic                    ram_we;
	logic [MAX_SET_BITS-1:0] ram_addr;
	logic [ROW_W-1:0]        ram_wdata;

	salc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(row)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, tot_evict_q, tot_miss_q, tot_hits_q, evict_q, miss_q, hits_q};

	// Effective geometry from the configuration registers.
	always_comb begin
		if (set_bits_q > MAX_SET_BITS) begin
			sb_eff = SBW'(MAX_SET_BITS);
		end else begin
			sb_eff = SBW'(set_bits_q);
		end
		if (ways_q == '0) begin
			w_eff = WCW'(1);
		end else if (ways_q > MAX_WAYS) begin
			w_eff = WCW'(MAX_WAYS);
		end else begin
			w_eff = WCW'(ways_q);
		end
	end

	// Split the incoming address into tag and set index.
	always_comb begin
		shift_total = TOT_W'(sb_eff) + TOT_W'(block_bits_q);
		addr_shift  = s_axis_tdata >> block_bits_q;
		if (shift_total >= TOT_W'(ADDR_W)) begin
			tag_in = '0;
		end else begin
			tag_in = s_axis_tdata >> shift_total;
		end
		for (int i = 0; i < MAX_SET_BITS; i++) begin
			set_in[i] = addr_shift[i] && (SBW'(i) < sb_eff);
		end
	end

	// Way under the comparator.
	always_comb begin
		cur_way   = row[way_q*WAY_W +: WAY_W];
		cur_valid = cur_way[WAY_W-1];
		cur_rank  = cur_way[TAG_W +: RW];
		cur_tag   = cur_way[TAG_W-1:0];
		scan_last = (WCW'(way_q) + WCW'(1)) == w_eff;
	end

	// Write-back row: promote the hit or filled way; age the ways more recent than a hit, or all others on a fill.
	always_comb begin
		logic          wv, nv;
		logic [RW-1:0] wr, nr;
		logic [TAG_W-1:0] wt, nt;
		logic          in_use;
		evict   = !hit_q && !free_v_q;
		tgt_way = free_v_q ? free_way_q : vic_way_q;
		row_new = row;
		for (int k = 0; k < MAX_WAYS; k++) begin
			wv     = row[k*WAY_W + WAY_W - 1];
			wr     = row[k*WAY_W + TAG_W +: RW];
			wt     = row[k*WAY_W +: TAG_W];
			nv     = wv;
			nr     = wr;
			nt     = wt;
			in_use = WCW'(k) < w_eff;
			if (hit_q) begin
				if (RW'(k) == hit_way_q) begin
					nr = '0;
				end else if (in_use && wv && wr < hit_rank_q && wr < RANK_MAX) begin
					nr = wr + RW'(1);
				end
			end else begin
				if (RW'(k) == tgt_way) begin
					nv = 1'b1;
					nr = '0;
					nt = tag_q;
				end else if (in_use && wv && wr < RANK_MAX) begin
					nr = wr + RW'(1);
				end
			end
			row_new[k*WAY_W +: WAY_W] = {nv, nr, nt};
		end
	end

	// Counts of this item and saturating totals.
	always_comb begin
		is_fetch = (op_q == OP_IFETCH);
		if (is_fetch) begin
			h_cnt = 2'd0;
			m_cnt = 1'b0;
			e_cnt = 1'b0;
		end else begin
			h_cnt = 2'(hit_q) + 2'(op_q == OP_MODIFY);
			m_cnt = !hit_q;
			e_cnt = evict;
		end
		sum_h = {1'b0, tot_hits_q} + (CNT_W+1)'(h_cnt);
		sum_m = {1'b0, tot_miss_q} + (CNT_W+1)'(m_cnt);
		sum_e = {1'b0, tot_evict_q} + (CNT_W+1)'(e_cnt);
	end

	always_comb begin
		out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = out_load && !is_fetch;
			ram_addr  = set_q;
			ram_wdata = row_new;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					state_d = (op_t'(s_axis_tuser) == OP_IFETCH) ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= RST_SET_BITS;
			block_bits_q <= RST_BLOCK_BITS;
			ways_q       <= RST_WAYS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[SET_BITS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[BLOCK_BITS_W-1:0];
				CFG_WAYS:       ways_q       <= cfg_data[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer control: clear sweep, way counter and scan flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			way_q    <= '0;
			hit_q    <= 1'b0;
			free_v_q <= 1'b0;
			vic_v_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + MAX_SET_BITS'(1);
			end
			if (in_accept) begin
				way_q    <= '0;
				hit_q    <= 1'b0;
				free_v_q <= 1'b0;
				vic_v_q  <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				way_q <= way_q + RW'(1);
				if (cur_valid && cur_tag == tag_q && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!cur_valid && !free_v_q) begin
					free_v_q <= 1'b1;
				end
				if (cur_valid) begin
					vic_v_q <= 1'b1;
				end
			end
		end
	end

	// Accepted item fields and scan payload: way numbers and ranks found by the comparator.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= op_t'(s_axis_tuser);
			tag_q <= tag_in;
			set_q <= set_in;
		end
		if (state_q == ST_SCAN) begin
			if (cur_valid && cur_tag == tag_q && !hit_q) begin
				hit_way_q  <= way_q;
				hit_rank_q <= cur_rank;
			end
			if (!cur_valid && !free_v_q) begin
				free_way_q <= way_q;
			end
			if (cur_valid && (!vic_v_q || cur_rank > vic_rank_q)) begin
				vic_way_q  <= way_q;
				vic_rank_q <= cur_rank;
			end
		end
	end

	// Output register and running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q   <= 1'b0;
			tot_hits_q  <= '0;
			tot_miss_q  <= '0;
			tot_evict_q <= '0;
		end else begin
			if (out_load) begin
				m_valid_q   <= 1'b1;
				tot_hits_q  <= sum_h[CNT_W] ? '1 : sum_h[CNT_W-1:0];
				tot_miss_q  <= sum_m[CNT_W] ? '1 : sum_m[CNT_W-1:0];
				tot_evict_q <= sum_e[CNT_W] ? '1 : sum_e[CNT_W-1:0];
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hits_q  <= h_cnt;
			miss_q  <= m_cnt;
			evict_q <= e_cnt;
		end
	end

	`SALC_ASSERT(a_scan_in_range, clk, arst_n, (state_q == ST_SCAN) |-> (WCW'(way_q) < w_eff))
	`SALC_ASSERT(a_evict_needs_miss, clk, arst_n, (m_valid_q && evict_q) |-> miss_q)
	`SALC_ASSERT_NEVER(a_hit_and_miss_twice, clk, arst_n, m_valid_q && miss_q && hits_q == 2'd2)
	`SALC_ASSERT(a_totals_grow, clk, arst_n, 1'b1 |=> (tot_hits_q >= $past(tot_hits_q)))
	`SALC_ASSERT(a_miss_has_target, clk, arst_n, (out_load && !is_fetch && !hit_q) |-> (free_v_q || vic_v_q))

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the set-associative LRU cache lookup block.
`timescale 1ns / 1ps

module tb_top;
	import salc_pkg::*;

	localparam int SHADOW_SET_BITS = DEF_MAX_SET_BITS;
	localparam int SHADOW_WAYS     = DEF_MAX_WAYS;
	localparam int SHADOW_LINES    = (1 << SHADOW_SET_BITS) * SHADOW_WAYS;
	localparam logic [2:0] RANK_MAX = 3'(SHADOW_WAYS - 1);
	// index that maps to no register; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int SETTLE_CYCLES   = 16;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
	} access_t;

	typedef struct packed {
		logic [1:0]       hits;
		logic             misses;
		logic             evictions;
		logic [CNT_W-1:0] total_hits;
		logic [CNT_W-1:0] total_misses;
		logic [CNT_W-1:0] total_evictions;
	} counts_t;

	typedef enum logic [1:0] {
		LK_HIT,
		LK_MISS,
		LK_EVICT
	} lookup_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [ADDR_W-1:0]     s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = OP_LOAD;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_BITS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	set_assoc_lru_cache_lookup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow cache: configuration, tag store and running totals
	logic [SET_BITS_W-1:0]   cfg_set_bits   = RST_SET_BITS;
	logic [BLOCK_BITS_W-1:0] cfg_block_bits = RST_BLOCK_BITS;
	logic [WAYS_W-1:0]       cfg_ways       = RST_WAYS;
	logic [TAG_W-1:0]        shadow_tag   [SHADOW_LINES];
	logic                    shadow_valid [SHADOW_LINES];
	logic [2:0]              shadow_rank  [SHADOW_LINES];
	logic [CNT_W-1:0]        sum_hits = '0;
	logic [CNT_W-1:0]        sum_misses = '0;
	logic [CNT_W-1:0]        sum_evictions = '0;

	access_t access_q[$];
	counts_t expected_counts[$];
	int      drv_cnt = 0;
	int      acc_cnt = 0;
	int      cfg_cnt = 0;
	int      result_cnt = 0;
	int      mismatches = 0;
	int      src_gap = 0;
	int      snk_gap = 0;
	int      shapes = 0;
	bit      calm = 1'b0;

	initial begin
		for (int n = 0; n < SHADOW_LINES; n++) begin
			shadow_tag[n] = '0;
			shadow_valid[n] = 1'b0;
			shadow_rank[n] = '0;
		end
	end

	function automatic void age_line(input int ln);
		if (shadow_rank[ln] < RANK_MAX)
			shadow_rank[ln] = shadow_rank[ln] + 3'd1;
	endfunction

	function automatic int unsigned eff_set_bits();
		return (cfg_set_bits > SHADOW_SET_BITS) ? SHADOW_SET_BITS : cfg_set_bits;
	endfunction

	// one lookup with LRU update of the addressed set
	function automatic lookup_t cache_access(input logic [ADDR_W-1:0] addr);
		int unsigned sb;
		int unsigned bb;
		int unsigned total;
		int          w;
		int          base;
		int          ln;
		int          free_way;
		int          victim;
		logic [TAG_W-1:0] tag;
		logic [2:0]  r;
		lookup_t     res;
		sb = eff_set_bits();
		bb = cfg_block_bits;
		w = (cfg_ways == 0) ? 1 : ((cfg_ways > SHADOW_WAYS) ? SHADOW_WAYS : int'(cfg_ways));
		total = sb + bb;
		tag = (total >= ADDR_W) ? '0 : (addr >> total);
		base = int'((addr >> bb) & ((64'd1 << sb) - 64'd1)) * SHADOW_WAYS;
		for (int i = 0; i < w; i++) begin
			ln = base + i;
			if (shadow_valid[ln] && shadow_tag[ln] == tag) begin
				r = shadow_rank[ln];
				for (int k = 0; k < w; k++) begin
					if (k != i && shadow_valid[base + k] && shadow_rank[base + k] < r)
						age_line(base + k);
				end
				shadow_rank[ln] = '0;
				return LK_HIT;
			end
		end
		free_way = -1;
		victim = -1;
		for (int i = 0; i < w; i++) begin
			ln = base + i;
			if (!shadow_valid[ln]) begin
				if (free_way < 0)
					free_way = i;
			end else if (victim < 0 || shadow_rank[ln] > shadow_rank[base + victim]) begin
				victim = i;
			end
		end
		res = LK_MISS;
		if (free_way < 0) begin
			free_way = victim;
			res = LK_EVICT;
		end
		for (int i = 0; i < w; i++) begin
			if (i != free_way && shadow_valid[base + i])
				age_line(base + i);
		end
		shadow_tag[base + free_way] = tag;
		shadow_valid[base + free_way] = 1'b1;
		shadow_rank[base + free_way] = '0;
		return res;
	endfunction

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a, input int unsigned b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W + 1)'(b);
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	function automatic counts_t predict_counts(input op_t op, input logic [ADDR_W-1:0] addr);
		int unsigned h;
		int unsigned m;
		int unsigned e;
		int          reps;
		lookup_t     lk;
		counts_t     c;
		h = 0;
		m = 0;
		e = 0;
		case (op)
			OP_MODIFY: reps = 2;
			OP_IFETCH: reps = 0;
			default:   reps = 1;
		endcase
		for (int n = 0; n < reps; n++) begin
			lk = cache_access(addr);
			if (lk == LK_HIT) begin
				h++;
			end else begin
				m++;
				if (lk == LK_EVICT)
					e++;
			end
		end
		sum_hits = sat_sum(sum_hits, h);
		sum_misses = sat_sum(sum_misses, m);
		sum_evictions = sat_sum(sum_evictions, e);
		c.hits = 2'(h);
		c.misses = 1'(m);
		c.evictions = 1'(e);
		c.total_hits = sum_hits;
		c.total_misses = sum_misses;
		c.total_evictions = sum_evictions;
		return c;
	endfunction

	task automatic check_field(input string fname, input int idx,
			input logic [CNT_W-1:0] want, input logic [CNT_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0d, got %0d", idx, fname, want, got);
		end
	endtask

	// sample handshakes on the rising edge; check results before queuing new ones
	always @(posedge clk) begin
		counts_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d with no access outstanding: %h",
							result_cnt, m_axis_tdata);
				end else begin
					want = expected_counts.pop_front();
					check_field("hits", result_cnt, CNT_W'(want.hits), CNT_W'(m_axis_tdata[1:0]));
					check_field("misses", result_cnt, CNT_W'(want.misses),
						CNT_W'(m_axis_tdata[2]));
					check_field("evictions", result_cnt, CNT_W'(want.evictions),
						CNT_W'(m_axis_tdata[3]));
					check_field("total_hits", result_cnt, want.total_hits, m_axis_tdata[35:4]);
					check_field("total_misses", result_cnt, want.total_misses,
						m_axis_tdata[67:36]);
					check_field("total_evictions", result_cnt, want.total_evictions,
						m_axis_tdata[99:68]);
				end
				result_cnt++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_counts.push_back(predict_counts(op_t'(s_axis_tuser), s_axis_tdata));
				acc_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SET_BITS:   cfg_set_bits = cfg_data[SET_BITS_W-1:0];
					CFG_BLOCK_BITS: cfg_block_bits = cfg_data[BLOCK_BITS_W-1:0];
					CFG_WAYS:       cfg_ways = cfg_data[WAYS_W-1:0];
					default:        ;
				endcase
				cfg_cnt++;
			end
		end
	end

	// access driver: hold the item until taken, then advance or idle
	always @(negedge clk) begin
		access_t cur;
		logic    nv;
		nv = 1'b0;
		if (arst_n) begin
			if (s_axis_tvalid && acc_cnt != drv_cnt) begin
				nv = 1'b1;
			end else if (src_gap > 0) begin
				src_gap--;
			end else if (access_q.size() != 0) begin
				cur = access_q.pop_front();
				nv = 1'b1;
				drv_cnt++;
				s_axis_tdata <= cur.addr;
				s_axis_tuser <= cur.op;
				if (!calm && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 12);
			end
		end
		s_axis_tvalid <= nv;
	end

	// result sink with random stall bursts
	always @(negedge clk) begin
		if (snk_gap > 0) begin
			snk_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!calm && $urandom_range(0, 7) == 0)
				snk_gap = $urandom_range(1, 12);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int seen;
		@(negedge clk);
		seen = cfg_cnt;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (cfg_cnt == seen);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_access(input op_t op, input logic [ADDR_W-1:0] addr);
		access_t a;
		a.op = op;
		a.addr = addr;
		access_q.push_back(a);
	endtask

	// few tags and few sets keep hits and evictions frequent
	function automatic logic [ADDR_W-1:0] pick_address();
		int unsigned sb;
		int unsigned bb;
		int unsigned total;
		logic [ADDR_W-1:0] tag;
		logic [ADDR_W-1:0] setv;
		logic [ADDR_W-1:0] off;
		sb = eff_set_bits();
		bb = cfg_block_bits;
		total = sb + bb;
		if ($urandom_range(0, 7) == 0)
			return {$urandom, $urandom};
		tag = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(0, 5));
		setv = ($urandom_range(0, 3) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
		off = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
		return ((total >= ADDR_W) ? 64'd0 : (tag << total))
			| ((setv & ((64'd1 << sb) - 64'd1)) << bb) | off;
	endfunction

	task automatic queue_random(input int n);
		op_t op;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0, 1, 2: op = OP_LOAD;
				3, 4:    op = OP_STORE;
				5, 6:    op = OP_MODIFY;
				default: op = OP_IFETCH;
			endcase
			push_access(op, pick_address());
		end
	endtask

	task automatic settle();
		while (access_q.size() != 0 || acc_cnt != drv_cnt || expected_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_shape(input logic [CFG_DATA_W-1:0] sb_val,
			input logic [CFG_DATA_W-1:0] bb_val, input logic [CFG_DATA_W-1:0] w_val,
			input int n);
		write_reg(CFG_SET_BITS, sb_val);
		write_reg(CFG_BLOCK_BITS, bb_val);
		write_reg(CFG_WAYS, w_val);
		shapes++;
		queue_random(n);
		settle();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset shape: 16 sets, 16-byte blocks, direct mapped
		shapes = 1;
		push_access(OP_LOAD, 64'h0);
		push_access(OP_LOAD, 64'hF);
		push_access(OP_STORE, '1);
		push_access(OP_MODIFY, 64'h8000_0000_0000_0000);
		push_access(OP_IFETCH, 64'h1234);
		push_access(OP_LOAD, 64'h100);
		push_access(OP_MODIFY, 64'h100);
		push_access(OP_STORE, 64'h0);
		push_access(OP_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
		push_access(OP_LOAD, 64'h5555_5555_5555_5555);
		push_access(OP_IFETCH, '1);
		push_access(OP_MODIFY, '1);
		push_access(OP_LOAD, 64'h10);
		push_access(OP_STORE, 64'h8000_0000_0000_0010);
		settle();

		run_shape(6'd2, 6'd6, 6'd4, 220);
		// no set bits: everything maps to set 0
		run_shape(6'd0, 6'd0, 6'd8, 220);
		// set bits and ways above their maxima; offset plus set reaches past bit 63
		run_shape(6'h3F, 6'd63, 6'h3F, 200);
		// zero ways acts as one way
		run_shape(6'd8, 6'd32, 6'd0, 200);
		write_reg(CFG_SPARE, 6'($urandom));
		run_shape(6'd3, 6'd5, 6'd6, 160);
		// shrink then grow the ways in use without clearing the store
		run_shape(6'd3, 6'd5, 6'd2, 120);
		run_shape(6'd3, 6'd5, 6'd7, 120);

		calm = 1'b1;
		run_shape(6'd1, 6'd2, 6'd8, 180);

		if (expected_counts.size() != 0)
			mismatches++;
		$display("ran %0d accesses through %0d cache shapes: %0d hits, %0d misses, %0d evictions",
			acc_cnt, shapes, sum_hits, sum_misses, sum_evictions);
		$display("checked %0d results, %0d mismatches", result_cnt, mismatches);
		if (mismatches == 0) begin
			$display("[set_assoc_lru_cache_lookup] OK");
		end else begin
			$display("[set_assoc_lru_cache_lookup] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout after %0d of %0d results", result_cnt, acc_cnt);
		$display("[set_assoc_lru_cache_lookup] ERROR");
		$finish;
	end

endmodule
